// ----- sv/assert_macros.svh -----
// Assertion helpers for the RTL files; msbbp_dp includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk_i edge, off while rst_ni is low.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// Check an implication on every rising clk_i edge, off while rst_ni is low.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: implication failed");

`endif

// ----- sv/msbbp_pkg.sv -----
`default_nettype none

package msbbp_pkg;

  // Field widths
  localparam int FIELD_W   = 32;
  localparam int COUNT_W   = 6;
  localparam int BYTE_W    = 8;
  localparam int PEND_W    = BYTE_W - 1;
  localparam int PCNT_W    = 3;
  localparam int REM_W     = 3;

  // Longest field accepted; larger counts saturate here
  localparam int MAX_RUN   = 32;
  localparam int RUN_LIMIT = (MAX_RUN < FIELD_W) ? MAX_RUN : FIELD_W;

  // Pending bits plus one field, and the MSB-aligned shift register
  localparam int COMB_W    = PEND_W + FIELD_W;
  localparam int ACC_W     = COMB_W + 1;

  // Stream word widths
  localparam int S_DATA_W  = 40;
  localparam int M_DATA_W  = 8;
  localparam int M_USER_W  = 2;

  // Input kind codes
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic advance;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_bytes;
    logic last_word;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/msbbp_dp.sv -----
`default_nettype none

module msbbp_dp import msbbp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dp_cmd_t            cmd_i,
  output      dp_status_t         status_o,
  input  wire logic               kind_i,
  input  wire logic [FIELD_W-1:0] field_value_i,
  input  wire logic [COUNT_W-1:0] bit_count_i,
  output      logic [BYTE_W-1:0]  byte_value_o,
  output      logic               byte_valid_o,
  output      logic               stream_end_o
);

  `include "assert_macros.svh"

  logic [PEND_W-1:0] pend_q, pend_d;
  logic [PCNT_W-1:0] pcnt_q, pcnt_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic              valid_q, valid_d;
  logic              end_q, end_d;

  logic [COUNT_W-1:0] n_sat;
  logic [FIELD_W:0]   mask_wide;
  logic [COMB_W-1:0]  combined;
  logic [COUNT_W-1:0] total;
  logic [ACC_W-1:0]   aligned;
  logic [BYTE_W-1:0]  pmask_wide;
  logic [BYTE_W-1:0]  flush_byte;

  // Saturate the count and merge the field below the pending bits
  always_comb begin
    n_sat     = (bit_count_i > COUNT_W'(RUN_LIMIT)) ? COUNT_W'(RUN_LIMIT) : bit_count_i;
    mask_wide = ((FIELD_W+1)'(1) << n_sat) - (FIELD_W+1)'(1);
    combined  = (COMB_W'(pend_q) << n_sat)
              | COMB_W'(field_value_i & mask_wide[FIELD_W-1:0]);
    total     = COUNT_W'(pcnt_q) + n_sat;
    aligned   = ACC_W'(combined) << (COUNT_W'(ACC_W) - total);
    pmask_wide = (BYTE_W'(1) << total[PCNT_W-1:0]) - BYTE_W'(1);
    flush_byte = BYTE_W'({1'b0, pend_q} << (4'(BYTE_W) - {1'b0, pcnt_q}));
  end

  // Load a new item or advance one byte
  always_comb begin
    pend_d  = pend_q;
    pcnt_d  = pcnt_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    valid_d = valid_q;
    end_d   = end_q;
    if (cmd_i.load) begin
      if (kind_i == KIND_FLUSH) begin
        acc_d   = {flush_byte, (ACC_W-BYTE_W)'(0)};
        rem_d   = REM_W'(1);
        valid_d = (pcnt_q != '0);
        end_d   = 1'b1;
        pend_d  = '0;
        pcnt_d  = '0;
      end else begin
        acc_d   = aligned;
        rem_d   = total[COUNT_W-1:PCNT_W];
        valid_d = 1'b1;
        end_d   = 1'b0;
        pend_d  = combined[PEND_W-1:0] & pmask_wide[PEND_W-1:0];
        pcnt_d  = total[PCNT_W-1:0];
      end
    end else if (cmd_i.advance) begin
      acc_d = acc_q << BYTE_W;
      rem_d = rem_q - REM_W'(1);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      pcnt_q <= '0;
      rem_q  <= '0;
    end else begin
      pend_q <= pend_d;
      pcnt_q <= pcnt_d;
      rem_q  <= rem_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    valid_q <= valid_d;
    end_q   <= end_d;
  end

  assign status_o.has_bytes = (kind_i == KIND_FLUSH) || (total[COUNT_W-1:PCNT_W] != '0);
  assign status_o.last_word = (rem_q == REM_W'(1));
  assign byte_value_o = acc_q[ACC_W-1 -: BYTE_W];
  assign byte_valid_o = valid_q;
  assign stream_end_o = end_q;

  `ASSERT_CLK(a_rem_range, rem_q <= REM_W'(4))
  `ASSERT_IMPL(a_load_when_drained, cmd_i.load, rem_q == '0)
  `ASSERT_IMPL(a_advance_has_word, cmd_i.advance, rem_q != '0)
  `ASSERT_IMPL(a_flush_empties, cmd_i.load && kind_i == KIND_FLUSH,
               ##1 (pcnt_q == '0 && rem_q == REM_W'(1)))

endmodule

`default_nettype wire

// ----- sv/msbbp_ctrl.sv -----
`default_nettype none

module msbbp_ctrl import msbbp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  output      logic       s_ready_o,
  output      logic       m_valid_o,
  input  wire logic       m_ready_i,
  input  wire dp_status_t status_i,
  output      dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i && status_i.has_bytes) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (m_ready_i && status_i.last_word) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    s_ready_o     = 1'b0;
    m_valid_o     = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.advance = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = s_valid_i;
      end
      ST_EMIT: begin
        m_valid_o     = 1'b1;
        cmd_o.advance = m_ready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/msb_first_bit_packer_unit.sv -----
`default_nettype none
// Output words of an input word start in the cycle after that input is taken.
// Output: a write gives B = 0..4 words from the byte shift register, one per cycle
//   while the master is ready; a flush gives one. One input word is in work at a time.
// Reset: rst_ni is asynchronous, active low; it empties the pending bits and
//   returns the controller to idle.

module msb_first_bit_packer_unit import msbbp_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  // [31:0] field_value, [37:32] bit_count, [39:38] zero
  input  wire logic [S_DATA_W-1:0] s_axis_tdata_i,
  // [0] kind
  input  wire logic                s_axis_tuser_i,
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [7:0] byte_value
  output      logic [M_DATA_W-1:0] m_axis_tdata_o,
  // [0] byte_valid, [1] stream_end
  output      logic [M_USER_W-1:0] m_axis_tuser_o,
  output      logic                m_axis_tlast_o
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       byte_valid;
  logic       stream_end;

  msbbp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  msbbp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .kind_i        (s_axis_tuser_i),
    .field_value_i (s_axis_tdata_i[FIELD_W-1:0]),
    .bit_count_i   (s_axis_tdata_i[FIELD_W +: COUNT_W]),
    .byte_value_o  (m_axis_tdata_o),
    .byte_valid_o  (byte_valid),
    .stream_end_o  (stream_end)
  );

  assign m_axis_tuser_o = {stream_end, byte_valid};
  assign m_axis_tlast_o = status.last_word;

endmodule

`default_nettype wire
